[design/cigid_pkg.sv]
// ----------------------------------------------------------------------------
// cigid_pkg
// Shared widths, character codes and types for the CIGAR identity block.
// ----------------------------------------------------------------------------
`default_nettype none

package cigid_pkg;

    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int THR_BITS   = 31;
    localparam int SYM_BITS   = 8;

    // sum of three counters needs two extra bits
    localparam int DEN_BITS   = COUNT_BITS + 2;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam int OUT_BYTES  = (2 * QUOT_BITS + 7) / 8;
    localparam int OUT_BITS   = OUT_BYTES * 8;
    localparam int STEP_BITS  = $clog2(FRAC_BITS + 1);
    localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [SYM_BITS-1:0] CH_0  = 8'h30;
    localparam logic [SYM_BITS-1:0] CH_9  = 8'h39;
    localparam logic [SYM_BITS-1:0] CH_M  = 8'h4D;
    localparam logic [SYM_BITS-1:0] CH_EQ = 8'h3D;
    localparam logic [SYM_BITS-1:0] CH_X  = 8'h58;
    localparam logic [SYM_BITS-1:0] CH_I  = 8'h49;
    localparam logic [SYM_BITS-1:0] CH_D  = 8'h44;

    typedef struct packed {
        logic [COUNT_BITS-1:0] match;
        logic [COUNT_BITS-1:0] mismatch;
        logic [COUNT_BITS-1:0] gap;
        logic [COUNT_BITS-1:0] long_gap;
    } cigid_counts_t;

    typedef enum logic [6:0] {
        ST_PARSE = 7'b0000001,
        ST_SUM   = 7'b0000010,
        ST_DIV1  = 7'b0000100,
        ST_WAIT1 = 7'b0001000,
        ST_DIV2  = 7'b0010000,
        ST_WAIT2 = 7'b0100000,
        ST_STORE = 7'b1000000
    } cigid_state_t;

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[design/cigid_parser.sv]
// ----------------------------------------------------------------------------
// cigid_parser
// Builds decimal run lengths and accumulates match, mismatch and gap counts.
// ----------------------------------------------------------------------------
`default_nettype none

module cigid_parser (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          accept,
    input  wire [cigid_pkg::SYM_BITS-1:0] symbol,
    input  wire                          clear,
    input  wire [cigid_pkg::THR_BITS-1:0] threshold,
    output cigid_pkg::cigid_counts_t     counts
);
    import cigid_pkg::*;

    logic [COUNT_BITS-1:0] run_reg, run_next;
    logic                  have_reg, have_next;
    cigid_counts_t         cnt_reg, cnt_next;

    logic                  is_digit;
    logic [COUNT_BITS+3:0] run_prod;
    logic                  is_long;

    assign is_digit = (symbol >= CH_0) && (symbol <= CH_9);
    assign run_prod = ({4'b0, run_reg} << 3) + ({4'b0, run_reg} << 1)
                    + (COUNT_BITS+4)'(symbol - CH_0);
    assign is_long  = CMP_BITS'(run_reg) >= CMP_BITS'(threshold);

    always_comb
    begin
        run_next  = run_reg;
        have_next = have_reg;
        cnt_next  = cnt_reg;
        if (clear)
        begin
            run_next  = '0;
            have_next = 1'b0;
            cnt_next  = '0;
        end
        else if (accept)
        begin
            if (is_digit)
            begin
                run_next  = (run_prod[COUNT_BITS+3:COUNT_BITS] != 4'b0) ?
                            COUNT_MAX : run_prod[COUNT_BITS-1:0];
                have_next = 1'b1;
            end
            else
            begin
                if (have_reg)
                begin
                    case (symbol) inside
                        CH_M, CH_EQ: cnt_next.match    = sat_add(cnt_reg.match, run_reg);
                        CH_X:        cnt_next.mismatch = sat_add(cnt_reg.mismatch, run_reg);
                        CH_I, CH_D:
                        begin
                            cnt_next.gap = sat_add(cnt_reg.gap, run_reg);
                            if (is_long)
                                cnt_next.long_gap = sat_add(cnt_reg.long_gap, run_reg);
                        end
                        default: ;
                    endcase
                end
                // any non-digit ends the pending run
                run_next  = '0;
                have_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            have_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            have_reg <= have_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign counts = cnt_reg;

endmodule

`default_nettype wire

[design/cigid_divider.sv]
// ----------------------------------------------------------------------------
// cigid_divider
// Restoring fractional divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cigid_divider (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire [cigid_pkg::COUNT_BITS-1:0] num,
    input  wire [cigid_pkg::DEN_BITS-1:0]   den,
    output logic                           done,
    output logic [cigid_pkg::QUOT_BITS-1:0] quot
);
    import cigid_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [DEN_BITS-1:0]  rem_reg;
    logic [DEN_BITS-1:0]  dvs_reg;
    logic [QUOT_BITS-1:0] q_reg;
    logic                 zero_reg;

    logic [DEN_BITS:0]    rem_shift;
    logic                 rem_ge;
    logic [DEN_BITS:0]    rem_sub;
    logic                 num_eq;

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign num_eq    = DEN_BITS'(num) == den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_BITS'(FRAC_BITS);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg  <= den;
            rem_reg  <= num_eq ? '0 : DEN_BITS'(num);
            q_reg    <= num_eq ? QUOT_BITS'(1) : '0;
            zero_reg <= (den == '0) || (DEN_BITS'(num) > den);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_ge ? rem_sub[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
            q_reg   <= {q_reg[QUOT_BITS-2:0], rem_ge};
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : q_reg;

endmodule

`default_nettype wire

[design/cigar_identity_with_gap_filter.sv]
// ----------------------------------------------------------------------------
// cigar_identity_with_gap_filter
// CIGAR string parser reporting alignment identity with and without long gaps.
// ----------------------------------------------------------------------------
// Characters arrive one per request; digits and op letters are taken one per
// cycle. The character marked tlast triggers two fractional divisions on one
// shared restoring divider, so after that character s_tready stays low through
// the sum, both divisions and the store, and longer while an earlier result
// still waits in the output register.
// The result sits in an output register and the next string may start while it
// waits to be taken. cfg_data may be written whenever the block idles.
`default_nettype none

module cigar_identity_with_gap_filter (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [cigid_pkg::THR_BITS-1:0]  cfg_data,   // long_gap_min
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [cigid_pkg::SYM_BITS-1:0]  s_tdata,    // symbol
    input  wire                            s_tlast,    // last
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // identity, identity_no_long_gaps, zero fill
    output logic [cigid_pkg::OUT_BITS-1:0] m_tdata
);
    import cigid_pkg::*;

    cigid_state_t          state_reg, state_next;
    logic [THR_BITS-1:0]   thr_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic [DEN_BITS-1:0]   den2_reg;
    logic [QUOT_BITS-1:0]  q1_reg;
    logic [QUOT_BITS-1:0]  q2_reg;
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_data_reg;

    cigid_counts_t         counts;
    logic                  in_accept;
    logic                  div_start;
    logic                  div_done;
    logic [DEN_BITS-1:0]   div_den;
    logic [QUOT_BITS-1:0]  div_quot;
    logic                  clear;
    logic                  load_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_PARSE);
    assign in_accept = s_tvalid && s_tready;
    assign div_start = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);
    assign div_den   = (state_reg == ST_DIV2) ? den2_reg : den_reg;
    assign clear     = (state_reg == ST_WAIT2) && div_done;
    assign load_out  = (state_reg == ST_STORE) && (!out_valid_reg || m_tready);

    cigid_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .symbol    (s_tdata),
        .clear     (clear),
        .threshold (thr_reg),
        .counts    (counts)
    );

    cigid_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (counts.match),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_PARSE: if (in_accept && s_tlast) state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIV1;
            ST_DIV1:  state_next = ST_WAIT1;
            ST_WAIT1: if (div_done) state_next = ST_DIV2;
            ST_DIV2:  state_next = ST_WAIT2;
            ST_WAIT2: if (div_done) state_next = ST_STORE;
            ST_STORE: if (load_out) state_next = ST_PARSE;
            default:  state_next = ST_PARSE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PARSE;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM)
            den_reg <= DEN_BITS'(counts.match) + DEN_BITS'(counts.mismatch)
                     + DEN_BITS'(counts.gap);
        // drop long gaps from the total; an impossible excess yields zero
        if (state_reg == ST_DIV1)
            den2_reg <= (DEN_BITS'(counts.long_gap) > den_reg) ?
                        '0 : den_reg - DEN_BITS'(counts.long_gap);
        if ((state_reg == ST_WAIT1) && div_done)
            q1_reg <= div_quot;
        if ((state_reg == ST_WAIT2) && div_done)
            q2_reg <= div_quot;
        if (load_out)
            out_data_reg <= OUT_BITS'({q2_reg, q1_reg});
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[design/cigid_checker.sv]
// ----------------------------------------------------------------------------
// cigid_checker
// Port-level checks for the CIGAR identity block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cigid_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            s_tlast,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [cigid_pkg::OUT_BITS-1:0]  m_tdata
);
    import cigid_pkg::*;

    localparam logic [QUOT_BITS-1:0] ONE = QUOT_BITS'(1) << FRAC_BITS;

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // hold off new characters while the divisions run
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during division");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[QUOT_BITS-1:0] <= ONE)
                  && (m_tdata[2*QUOT_BITS-1:QUOT_BITS] <= ONE))
        else $error("identity above one");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> (2 * QUOT_BITS)) == '0)
        else $error("fill bits not zero");

endmodule

bind cigar_identity_with_gap_filter cigid_checker u_cigid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CIGAR identity block with long-gap filtering.
// Streams CIGAR strings one character per request. A fixed table of strings
// goes first, then random well-formed strings mixed with broken ones, under
// several gap thresholds. Each result is compared with a table entry or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import cigid_pkg::*;

    localparam logic [SYM_BITS-1:0] CH_S = 8'h53;
    localparam logic [SYM_BITS-1:0] CH_H = 8'h48;
    localparam logic [SYM_BITS-1:0] CH_N = 8'h4E;
    localparam logic [SYM_BITS-1:0] CH_P = 8'h50;

    localparam longint unsigned RUN_CAP = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 360;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 50;

    typedef struct packed {
        logic [QUOT_BITS-1:0] trim;
        logic [QUOT_BITS-1:0] ident;
    } identity_pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [THR_BITS-1:0]   cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SYM_BITS-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_BITS-1:0]   m_tdata;

    cigar_identity_with_gap_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // model state
    longint unsigned gap_thr;
    longint unsigned run_len;
    bit              have_run;
    longint unsigned n_match;
    longint unsigned n_mismatch;
    longint unsigned n_gap;
    longint unsigned n_long;

    identity_pair_t identity_q[$];
    identity_pair_t typed_q[$];
    logic [SYM_BITS-1:0] char_buf[$];

    int errors       = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int thr_writes   = 0;
    bit quiet_in     = 0;
    bit quiet_out    = 0;
    bit hold_out     = 0;

    // directed strings; the final character of each carries tlast
    string          cigar_rows [4] = '{"5M", "3X2=1I", "9999999999M1D", "H1Z7"};
    bit             row_known  [4] = '{1'b1, 1'b0, 1'b1, 1'b1};
    identity_pair_t row_expect [4] = '{
        {17'd65536, 17'd65536},
        {17'd0,     17'd0},
        {17'd65536, 17'd65535},
        {17'd0,     17'd0}
    };

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint unsigned clamp_add(input longint unsigned a,
                                                  input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > RUN_CAP) ? RUN_CAP : s;
    endfunction

    function automatic logic [QUOT_BITS-1:0] q_fraction(input longint unsigned num,
                                                        input longint unsigned den);
        longint unsigned q;
        if (den == 0 || num > den)
            return '0;
        q = (num << FRAC_BITS) / den;
        return q[QUOT_BITS-1:0];
    endfunction

    task automatic take_symbol(input logic [SYM_BITS-1:0] sym, input logic lst);
        longint unsigned v;
        longint unsigned den;
        longint unsigned den2;
        identity_pair_t  e;
        if (sym >= CH_0 && sym <= CH_9)
        begin
            v = run_len * 10 + longint'(sym - CH_0);
            run_len = (v > RUN_CAP) ? RUN_CAP : v;
            have_run = 1'b1;
        end
        else
        begin
            if (have_run)
            begin
                if (sym == CH_M || sym == CH_EQ)
                    n_match = clamp_add(n_match, run_len);
                else if (sym == CH_X)
                    n_mismatch = clamp_add(n_mismatch, run_len);
                else if (sym == CH_I || sym == CH_D)
                begin
                    n_gap = clamp_add(n_gap, run_len);
                    if (run_len >= gap_thr)
                        n_long = clamp_add(n_long, run_len);
                end
            end
            run_len = 0;
            have_run = 1'b0;
        end
        if (lst)
        begin
            den  = n_match + n_mismatch + n_gap;
            den2 = (n_long > den) ? 0 : den - n_long;
            e.ident = q_fraction(n_match, den);
            e.trim  = q_fraction(n_match, den2);
            if (typed_q.size() != 0)
                e = typed_q.pop_front();
            identity_q.push_back(e);
            // a run still pending on the last character is dropped
            run_len = 0;
            have_run = 1'b0;
            n_match = 0;
            n_mismatch = 0;
            n_gap = 0;
            n_long = 0;
        end
    endtask

    task automatic report(input string field, input logic [QUOT_BITS-1:0] exp_v,
                          input logic [QUOT_BITS-1:0] got_v);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    endtask

    // sample requests and results at the rising edge
    identity_pair_t       want;
    logic [QUOT_BITS-1:0] got_ident;
    logic [QUOT_BITS-1:0] got_trim;
    logic [QUOT_BITS-1:0] got_pad;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                gap_thr = 64'(cfg_data);
                thr_writes++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got_ident = m_tdata[QUOT_BITS-1:0];
                got_trim  = m_tdata[2*QUOT_BITS-1:QUOT_BITS];
                got_pad   = QUOT_BITS'(m_tdata[OUT_BITS-1:2*QUOT_BITS]);
                if (identity_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = identity_q.pop_front();
                    if (got_ident !== want.ident)
                        report("identity", want.ident, got_ident);
                    if (got_trim !== want.trim)
                        report("identity_no_long_gaps", want.trim, got_trim);
                    if (got_pad !== '0)
                        report("zero fill", '0, got_pad);
                end
            end
            if (s_tvalid && s_tready)
                take_symbol(s_tdata, s_tlast);
        end
    end

    // result side: random stalls, one long hold on request
    initial
    begin : sink
        int stall;
        int k;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                hold_out = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (quiet_out)
                m_tready <= 1'b1;
            else
            begin
                k = $urandom_range(0, 99);
                if (k < 70)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    stall = (k < 94) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int input_gap();
        int k;
        if (quiet_in)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // call at a falling edge; returns at the falling edge after the request
    task automatic send_symbol(input logic [SYM_BITS-1:0] sym, input logic lst);
        int gap;
        gap = input_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // drop valid and wait for every outstanding result, then let the block settle
    task automatic drain_results(input int extra);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (identity_q.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint unsigned pick_run();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65)
            return 64'($urandom_range(1, 60));
        if (k < 80)
            return 64'($urandom_range(61, 100000));
        if (k < 85)
            return 0;
        if (k < 95)
            return 64'($urandom);
        return {$urandom, $urandom} % 64'd1_000_000_000_000;
    endfunction

    task automatic append_run(input longint unsigned n);
        logic [SYM_BITS-1:0] digs[$];
        logic [SYM_BITS-1:0] d;
        longint unsigned     v;
        int                  z;
        v = n;
        do
        begin
            d = CH_0 + SYM_BITS'(v % 10);
            digs.push_front(d);
            v = v / 10;
        end
        while (v != 0);
        // leading zeros now and then
        if ($urandom_range(0, 19) == 0)
        begin
            z = $urandom_range(1, 2);
            repeat (z) digs.push_front(CH_0);
        end
        foreach (digs[i])
            char_buf.push_back(digs[i]);
    endtask

    task automatic build_cigar();
        logic [SYM_BITS-1:0] op_set[9];
        int ops;
        int k;
        op_set = '{CH_M, CH_I, CH_D, CH_N, CH_S, CH_H, CH_P, CH_EQ, CH_X};
        char_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // broken string: random bytes, digit-heavy
            ops = $urandom_range(1, 6);
            repeat (ops)
            begin
                if ($urandom_range(0, 1) == 0)
                    char_buf.push_back(SYM_BITS'($urandom_range(0, 255)));
                else
                    char_buf.push_back(CH_0 + SYM_BITS'($urandom_range(0, 9)));
            end
            return;
        end
        ops = $urandom_range(1, 8);
        repeat (ops)
        begin
            k = $urandom_range(0, 99);
            if (k < 88)
            begin
                append_run(pick_run());
                char_buf.push_back(op_set[$urandom_range(0, 8)]);
            end
            else if (k < 92)
                char_buf.push_back(op_set[$urandom_range(0, 8)]);
            else if (k < 96)
            begin
                append_run(pick_run());
                char_buf.push_back(SYM_BITS'($urandom_range(0, 255)));
            end
            else
                char_buf.push_back(SYM_BITS'($urandom_range(0, 255)));
        end
        // pending digits at the end get discarded
        if ($urandom_range(0, 19) == 0)
            append_run(pick_run());
    endtask

    task automatic send_cigar();
        foreach (char_buf[i])
            send_symbol(char_buf[i], i == char_buf.size() - 1);
    endtask

    initial
    begin : stimulus
        string row;
        int    p;
        int    phase_start;
        bit    paused;
        gap_thr    = 0;
        run_len    = 0;
        have_run   = 1'b0;
        n_match    = 0;
        n_mismatch = 0;
        n_gap      = 0;
        n_long     = 0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        paused     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed strings under the reset threshold
        for (int i = 0; i < 4; i++)
        begin
            row = cigar_rows[i];
            if (row_known[i])
                typed_q.push_back(row_expect[i]);
            for (int c = 0; c < row.len(); c++)
                send_symbol(row[c], c == row.len() - 1);
        end
        drain_results(SETTLE_CYCLES);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       write_threshold(31'd1);
                1:       write_threshold(THR_BITS'($urandom_range(2, 40)));
                2:       write_threshold({THR_BITS{1'b1}});
                3:       write_threshold(THR_BITS'($urandom_range(1, 20000)));
                default: write_threshold('0);
            endcase
            phase_start = items_sent;
            quiet_in  = (p == 1 || p == 3);
            quiet_out = (p == 3);
            // hold results off while the sender keeps offering characters
            if (p == 1)
                hold_out = 1'b1;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if (items_sent - phase_start >= 120)
                begin
                    quiet_in  = 1'b0;
                    quiet_out = 1'b0;
                end
                if (p == 2 && !paused && items_sent - phase_start >= 180)
                begin
                    paused = 1'b1;
                    drain_results(0);
                end
                build_cigar();
                send_cigar();
            end
            drain_results(SETTLE_CYCLES);
        end

        $display("Checked %0d identity results from %0d characters across %0d thresholds.",
                 results_seen, items_sent, thr_writes + 1);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
